// File: rtl/fdu_pkg.sv
// shared types, constants and saturation helper for the 1-d field update block
`default_nettype none

package fdu_pkg;

    localparam int CELLS_DEF = 64;
    localparam int SRC_DIV   = 4;

    localparam int DATA_W    = 32;
    localparam int PROBE_W   = 6;
    localparam int FRAC_W    = 24;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int PROD_W    = DIFF_W + DATA_W;
    localparam int SUM_W     = PROD_W + 1 - FRAC_W;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [FRAC_W-1:0] ROUND_HALF = {1'b1, {(FRAC_W-1){1'b0}}};

    localparam logic signed [DATA_W-1:0] COEF_E_RST   = DATA_W'(8388608);
    localparam logic signed [DATA_W-1:0] COEF_H_RST   = DATA_W'(8388608);
    localparam logic signed [DATA_W-1:0] MUR_COEF_RST = '0;

    localparam logic BND_REFLECT = 1'b0;
    localparam logic BND_MUR     = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_E,
        REG_COEF_H,
        REG_MUR_COEF,
        REG_BND_MODE
    } cfg_reg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] e;
        logic signed [DATA_W-1:0] h;
    } cell_t;

    // what travels alongside an operand through the update pipeline
    typedef struct packed {
        logic signed [DATA_W-1:0] other;
        logic                     live;
        logic                     upd;
        logic                     src_hit;
        logic                     probe_hit;
    } tag_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     clip;
    } sat_t;

    function automatic sat_t sat32(input logic signed [SUM_W-1:0] v);
        sat_t r;
        if ((v[SUM_W-1:DATA_W-1] == '0) || (v[SUM_W-1:DATA_W-1] == '1))
        begin
            r.val  = v[DATA_W-1:0];
            r.clip = 1'b0;
        end
        else
        begin
            r.val  = v[SUM_W-1] ? DATA_MIN : DATA_MAX;
            r.clip = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/fdu_cell.sv
// one grid cell of the shift chain, holding its electric and magnetic value
`default_nettype none

module fdu_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          shift,
    input  wire logic          load_e,
    input  wire logic signed [fdu_pkg::DATA_W-1:0] load_val,
    input  wire fdu_pkg::cell_t nxt,
    output fdu_pkg::cell_t     cur
);
    import fdu_pkg::*;

    cell_t cell_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (load_e)
        begin
            cell_reg.e <= load_val;
        end
        else if (shift)
        begin
            cell_reg <= nxt;
        end
    end

    assign cur = cell_reg;

endmodule

`default_nettype wire

// File: rtl/fdu_update.sv
// three-stage difference, scale and saturating accumulate unit
`default_nettype none

module fdu_update (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic signed [fdu_pkg::DATA_W-1:0] op_a,
    input  wire logic signed [fdu_pkg::DATA_W-1:0] op_b,
    input  wire logic signed [fdu_pkg::DATA_W-1:0] coef,
    input  wire logic signed [fdu_pkg::DATA_W-1:0] base,
    input  wire fdu_pkg::tag_t tag_in,
    output logic signed [fdu_pkg::DATA_W-1:0] result,
    output logic               clip,
    output fdu_pkg::tag_t      tag_out
);
    import fdu_pkg::*;

    logic signed [DIFF_W-1:0]  s1_diff_reg;
    logic signed [DATA_W-1:0]  s1_coef_reg;
    logic signed [DATA_W-1:0]  s1_base_reg;
    tag_t                      s1_tag_reg;

    logic signed [PROD_W-1:0]  s2_prod_reg;
    logic signed [DATA_W-1:0]  s2_base_reg;
    tag_t                      s2_tag_reg;

    logic signed [DATA_W-1:0]  s3_res_reg;
    logic                      s3_clip_reg;
    tag_t                      s3_tag_reg;

    logic signed [DIFF_W-1:0]  diff_next;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W:0]    wide_sum;
    sat_t                      sum_sat;
    logic signed [DATA_W-1:0]  s3_res_next;
    logic                      s3_clip_next;

    assign diff_next = {op_a[DATA_W-1], op_a} - {op_b[DATA_W-1], op_b};
    assign prod_next = s1_diff_reg * s1_coef_reg;

    // base sits above the fraction with the rounding half below, so one add rounds
    assign wide_sum = $signed({{(PROD_W + 1 - DATA_W - FRAC_W){s2_base_reg[DATA_W-1]}},
                               s2_base_reg, ROUND_HALF})
                    + $signed({s2_prod_reg[PROD_W-1], s2_prod_reg});

    always_comb
    begin
        sum_sat = sat32(wide_sum[PROD_W:FRAC_W]);
        if (s2_tag_reg.upd)
        begin
            s3_res_next  = sum_sat.val;
            s3_clip_next = sum_sat.clip;
        end
        else
        begin
            s3_res_next  = s2_base_reg;
            s3_clip_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg  <= '0;
            s2_tag_reg  <= '0;
            s3_tag_reg  <= '0;
            s3_clip_reg <= 1'b0;
        end
        else
        begin
            s1_tag_reg  <= tag_in;
            s2_tag_reg  <= s1_tag_reg;
            s3_tag_reg  <= s2_tag_reg;
            s3_clip_reg <= s3_clip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_diff_reg <= diff_next;
        s1_coef_reg <= coef;
        s1_base_reg <= base;
        s2_prod_reg <= prod_next;
        s2_base_reg <= s1_base_reg;
        s3_res_reg  <= s3_res_next;
    end

    assign result  = s3_res_reg;
    assign clip    = s3_clip_reg;
    assign tag_out = s3_tag_reg;

endmodule

`default_nettype wire

// File: rtl/fdtd_1d_field_update.sv
// top level: cell chain, shared update unit, boundary sequencing and probe output
//
// One input transfer on in_valid/in_stall is one time step of the grid: the source
// amplitude added at cell CELLS/4 and the cell to report afterwards. One output
// transfer on out_valid/out_stall follows per step with E and H at the probe cell
// and a flag set when any sum of the step clipped.
// The fields rotate through a chain of CELLS cells closed by the three-stage update
// unit. Each step runs a magnetic pass over the grid, then an electric pass, then
// the two ends through the same multiplier, then a finishing state.
// in_stall is high while a step is in progress. A finished result waits in the
// output register; if out_stall holds it there, the next step runs meanwhile and
// only its final cycle waits for the register to free.
// Reset clears all fields and boundary history and loads the register defaults.
// Configuration writes on cfg_we take effect at once, so they belong between steps.
`default_nettype none

module fdtd_1d_field_update #(
    parameter int CELLS = fdu_pkg::CELLS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire logic signed [fdu_pkg::DATA_W-1:0] source_value,
    input  wire logic [fdu_pkg::PROBE_W-1:0]       probe_index,
    output logic      out_valid,
    input  wire logic out_stall,
    output logic signed [fdu_pkg::DATA_W-1:0] probe_electric,
    output logic signed [fdu_pkg::DATA_W-1:0] probe_magnetic,
    output logic      saturated,
    input  wire logic cfg_we,
    input  wire logic [fdu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fdu_pkg::DATA_W-1:0]    cfg_data
);
    import fdu_pkg::*;

    localparam int CW = $clog2(CELLS + 3);
    localparam int XW = CW + PROBE_W;
    localparam logic [CW-1:0] LAST_CNT = CW'(CELLS + 2);
    localparam logic [CW-1:0] SRC_CNT  = CW'(CELLS / SRC_DIV);
    localparam logic [2:0] BND_LEFT  = 3'd3;
    localparam logic [2:0] BND_LAST  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HPASS,
        S_EPASS,
        S_BND,
        S_FIN
    } state_t;

    state_t state_reg;
    logic [CW-1:0] cnt_reg;
    logic [2:0]    bcnt_reg;
    logic          flag_reg;
    logic          sat_reg;
    logic          out_valid_reg;
    logic signed [DATA_W-1:0] out_e_reg;
    logic signed [DATA_W-1:0] out_h_reg;
    logic signed [DATA_W-1:0] lep_reg;
    logic signed [DATA_W-1:0] rep_reg;
    logic signed [DATA_W-1:0] lnp_reg;
    logic signed [DATA_W-1:0] rnp_reg;

    logic signed [DATA_W-1:0] coef_e_reg;
    logic signed [DATA_W-1:0] coef_h_reg;
    logic signed [DATA_W-1:0] mur_coef_reg;
    logic                     bmode_reg;

    logic signed [DATA_W-1:0] src_reg;
    logic [PROBE_W-1:0]       probe_reg;
    logic signed [DATA_W-1:0] hprev_reg;
    logic signed [DATA_W-1:0] prb_e_reg;
    logic signed [DATA_W-1:0] prb_h_reg;

    cell_t cell_q [CELLS];
    cell_t tail_val;
    logic  shift;
    logic  elem_live;
    logic  accept;
    logic  load_l;
    logic  load_r;
    logic signed [DATA_W-1:0] bnd_val;

    logic signed [DATA_W-1:0] u_a;
    logic signed [DATA_W-1:0] u_b;
    logic signed [DATA_W-1:0] u_coef;
    logic signed [DATA_W-1:0] u_base;
    tag_t                     u_tag_in;
    logic signed [DATA_W-1:0] u_res;
    logic                     u_clip;
    tag_t                     u_tag;
    sat_t                     src_sum;
    logic signed [DATA_W-1:0] fin_e;
    logic signed [DATA_W-1:0] fin_h;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign shift     = (state_reg == S_HPASS) || (state_reg == S_EPASS);
    assign elem_live = cnt_reg < CW'(CELLS);

    // cell chain: every cell takes its right neighbour, the last takes the unit output
    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        cell_t nxt;
        logic  ld;
        if (k == CELLS - 1)
        begin : g_tail
            assign nxt = tail_val;
            assign ld  = load_r;
        end
        else if (k == 0)
        begin : g_head
            assign nxt = cell_q[k+1];
            assign ld  = load_l;
        end
        else
        begin : g_mid
            assign nxt = cell_q[k+1];
            assign ld  = 1'b0;
        end
        fdu_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (shift),
            .load_e   (ld),
            .load_val (bnd_val),
            .nxt      (nxt),
            .cur      (cell_q[k])
        );
    end

    // operand selection for the shared update unit
    always_comb
    begin
        u_a      = cell_q[1].e;
        u_b      = lep_reg;
        u_coef   = mur_coef_reg;
        u_base   = lnp_reg;
        u_tag_in = '0;
        case (state_reg)
            S_HPASS:
            begin
                u_a               = cell_q[1].e;
                u_b               = cell_q[0].e;
                u_coef            = coef_h_reg;
                u_base            = cell_q[0].h;
                u_tag_in.other    = cell_q[0].e;
                u_tag_in.live     = elem_live;
                u_tag_in.upd      = cnt_reg < CW'(CELLS - 1);
            end
            S_EPASS:
            begin
                u_a                = cell_q[0].h;
                u_b                = hprev_reg;
                u_coef             = coef_e_reg;
                u_base             = cell_q[0].e;
                u_tag_in.other     = cell_q[0].h;
                u_tag_in.live      = elem_live;
                u_tag_in.upd       = (cnt_reg != '0) && (cnt_reg <= CW'(CELLS - 2));
                u_tag_in.src_hit   = cnt_reg == SRC_CNT;
                u_tag_in.probe_hit = elem_live && (XW'(cnt_reg) == XW'(probe_reg));
            end
            S_BND:
            begin
                // left end goes in first, right end in the cycle after
                u_tag_in.upd = 1'b1;
                if (bcnt_reg != '0)
                begin
                    u_a    = cell_q[CELLS-2].e;
                    u_b    = rep_reg;
                    u_base = rnp_reg;
                end
            end
            default:
            begin
                u_tag_in = '0;
            end
        endcase
    end

    fdu_update u_update (
        .clk     (clk),
        .rst_n   (rst_n),
        .op_a    (u_a),
        .op_b    (u_b),
        .coef    (u_coef),
        .base    (u_base),
        .tag_in  (u_tag_in),
        .result  (u_res),
        .clip    (u_clip),
        .tag_out (u_tag)
    );

    assign src_sum = sat32({{(SUM_W-DATA_W){u_res[DATA_W-1]}}, u_res}
                         + {{(SUM_W-DATA_W){src_reg[DATA_W-1]}}, src_reg});

    always_comb
    begin
        if (state_reg == S_HPASS)
        begin
            tail_val.e = u_tag.other;
            tail_val.h = u_res;
        end
        else
        begin
            tail_val.e = u_tag.src_hit ? src_sum.val : u_res;
            tail_val.h = u_tag.other;
        end
    end

    assign load_l  = (state_reg == S_BND) && (bcnt_reg == BND_LEFT);
    assign load_r  = (state_reg == S_BND) && (bcnt_reg == BND_LAST);
    assign bnd_val = (bmode_reg == BND_MUR) ? u_res : '0;

    // probe value after the ends are settled
    always_comb
    begin
        fin_e = prb_e_reg;
        fin_h = prb_h_reg;
        if (XW'(probe_reg) >= XW'(CELLS))
        begin
            fin_e = '0;
            fin_h = '0;
        end
        else if (probe_reg == '0)
        begin
            fin_e = cell_q[0].e;
        end
        else if (XW'(probe_reg) == XW'(CELLS - 1))
        begin
            fin_e = cell_q[CELLS-1].e;
            fin_h = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_e_reg   <= COEF_E_RST;
            coef_h_reg   <= COEF_H_RST;
            mur_coef_reg <= MUR_COEF_RST;
            bmode_reg    <= BND_REFLECT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COEF_E:   coef_e_reg   <= cfg_data;
                REG_COEF_H:   coef_h_reg   <= cfg_data;
                REG_MUR_COEF: mur_coef_reg <= cfg_data;
                REG_BND_MODE: bmode_reg    <= cfg_data[0];
                default:      bmode_reg    <= bmode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            bcnt_reg      <= '0;
            flag_reg      <= 1'b0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_e_reg     <= '0;
            out_h_reg     <= '0;
            lep_reg       <= '0;
            rep_reg       <= '0;
            lnp_reg       <= '0;
            rnp_reg       <= '0;
        end
        else
        begin
            // the finishing state reloads the output register itself
            if (out_valid_reg && !out_stall && (state_reg != S_FIN))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        lep_reg   <= cell_q[0].e;
                        rep_reg   <= cell_q[CELLS-1].e;
                        flag_reg  <= 1'b0;
                        cnt_reg   <= '0;
                        state_reg <= S_HPASS;
                    end
                end
                S_HPASS:
                begin
                    flag_reg <= flag_reg | (u_tag.live & u_clip);
                    if (cnt_reg == LAST_CNT)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_EPASS;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_EPASS:
                begin
                    flag_reg <= flag_reg | (u_tag.live & u_clip)
                              | (u_tag.src_hit & src_sum.clip);
                    if (cnt_reg == LAST_CNT)
                    begin
                        cnt_reg   <= '0;
                        bcnt_reg  <= '0;
                        state_reg <= S_BND;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_BND:
                begin
                    if ((bcnt_reg == BND_LEFT) || (bcnt_reg == BND_LAST))
                    begin
                        flag_reg <= flag_reg | ((bmode_reg == BND_MUR) & u_clip);
                    end
                    if (bcnt_reg == BND_LAST)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        bcnt_reg <= bcnt_reg + 1'b1;
                    end
                end
                S_FIN:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_e_reg     <= fin_e;
                        out_h_reg     <= fin_h;
                        sat_reg       <= flag_reg;
                        out_valid_reg <= 1'b1;
                        lnp_reg       <= cell_q[1].e;
                        rnp_reg       <= cell_q[CELLS-2].e;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_reg   <= source_value;
            probe_reg <= probe_index;
        end
        if (shift)
        begin
            hprev_reg <= cell_q[0].h;
        end
        if ((state_reg == S_EPASS) && u_tag.probe_hit)
        begin
            prb_e_reg <= tail_val.e;
            prb_h_reg <= tail_val.h;
        end
    end

    assign in_stall       = state_reg != S_IDLE;
    assign out_valid      = out_valid_reg;
    assign probe_electric = out_e_reg;
    assign probe_magnetic = out_h_reg;
    assign saturated      = sat_reg;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_HPASS))
        else $error("accepted transfer did not start the magnetic pass");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_FIN))
        else $error("result raised outside the finishing state");

    a_pass_chain: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_HPASS) && (cnt_reg == LAST_CNT))
        |=> ((state_reg == S_EPASS) && (cnt_reg == '0)))
        else $error("electric pass did not follow the magnetic pass");

    a_bnd_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BND) |-> (bcnt_reg <= BND_LAST))
        else $error("boundary sequence counter overran");
`endif

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// self-checking bench for the 1-d field update block: directed table, then random grid steps
module tb_top;
    import fdu_pkg::*;

    localparam int NCELL      = CELLS_DEF;
    localparam int SRC_CELL   = NCELL / SRC_DIV;
    localparam int RAND_ITEMS = 1850;
    localparam int LATENCY    = 2 * NCELL + 12;
    localparam int CYCLE_CAP  = 5000000;

    typedef logic signed [DATA_W-1:0] q24_t;
    typedef logic signed [65:0]       wide_t;

    typedef struct packed {
        q24_t e;
        q24_t h;
        logic sat;
    } probe_rec_t;

    typedef struct packed {
        logic             is_cfg;
        cfg_reg_t         cfg_sel;
        logic [31:0]      cfg_val;
        q24_t             src;
        logic [5:0]       probe;
        logic             typed;
        q24_t             exp_e;
        q24_t             exp_h;
        logic             exp_sat;
    } stim_row_t;

    // typed results only where the grid is still trivially known
    localparam stim_row_t DIRECTED [25] = '{
        '{1'b0, REG_COEF_E,   32'h0,        32'h00000000, 6'd0,  1'b1, 32'h0, 32'h0, 1'b0},
        '{1'b0, REG_COEF_E,   32'h0,        32'h00000000, 6'd63, 1'b1, 32'h0, 32'h0, 1'b0},
        '{1'b0, REG_COEF_E,   32'h0,        32'h7FFFFFFF, 6'd16, 1'b1, 32'h7FFFFFFF, 32'h0, 1'b0},
        '{1'b0, REG_COEF_E,   32'h0,        32'h7FFFFFFF, 6'd16, 1'b0, 32'h0, 32'h0, 1'b0},
        '{1'b0, REG_COEF_E,   32'h0,        32'h80000000, 6'd16, 1'b0, 32'h0, 32'h0, 1'b0},
        '{1'b0, REG_COEF_E,   32'h0,        32'h80000000, 6'd15, 1'b0, 32'h0, 32'h0, 1'b0},
        '{1'b0, REG_COEF_E,   32'h0,        32'h00000000, 6'd17, 1'b0, 32'h0, 32'h0, 1'b0},
        '{1'b0, REG_COEF_E,   32'h0,        32'h00000001, 6'd62, 1'b0, 32'h0, 32'h0, 1'b0},
        '{1'b1, REG_BND_MODE, 32'hFFFFFFFE, 32'h0,        6'd0,  1'b0, 32'h0, 32'h0, 1'b0},
        '{1'b1, REG_COEF_E,   32'h7FFFFFFF, 32'h0,        6'd0,  1'b0, 32'h0, 32'h0, 1'b0},
        '{1'b1, REG_COEF_H,   32'h80000000, 32'h0,        6'd0,  1'b0, 32'h0, 32'h0, 1'b0},
        '{1'b0, REG_COEF_E,   32'h0,        32'hFFFFFFFF, 6'd1,  1'b0, 32'h0, 32'h0, 1'b0},
        '{1'b0, REG_COEF_E,   32'h0,        32'h00000000, 6'd0,  1'b0, 32'h0, 32'h0, 1'b0},
        '{1'b1, REG_BND_MODE, 32'h00000001, 32'h0,        6'd0,  1'b0, 32'h0, 32'h0, 1'b0},
        '{1'b1, REG_MUR_COEF, 32'h7FFFFFFF, 32'h0,        6'd0,  1'b0, 32'h0, 32'h0, 1'b0},
        '{1'b0, REG_COEF_E,   32'h0,        32'h01000000, 6'd0,  1'b0, 32'h0, 32'h0, 1'b0},
        '{1'b0, REG_COEF_E,   32'h0,        32'h00000000, 6'd63, 1'b0, 32'h0, 32'h0, 1'b0},
        '{1'b1, REG_MUR_COEF, 32'h80000000, 32'h0,        6'd0,  1'b0, 32'h0, 32'h0, 1'b0},
        '{1'b0, REG_COEF_E,   32'h0,        32'h7FFFFFFF, 6'd1,  1'b0, 32'h0, 32'h0, 1'b0},
        '{1'b0, REG_COEF_E,   32'h0,        32'h80000000, 6'd62, 1'b0, 32'h0, 32'h0, 1'b0},
        '{1'b1, REG_COEF_E,   32'h00000000, 32'h0,        6'd0,  1'b0, 32'h0, 32'h0, 1'b0},
        '{1'b1, REG_COEF_H,   32'h00000000, 32'h0,        6'd0,  1'b0, 32'h0, 32'h0, 1'b0},
        '{1'b0, REG_COEF_E,   32'h0,        32'h00000000, 6'd31, 1'b0, 32'h0, 32'h0, 1'b0},
        '{1'b1, REG_MUR_COEF, 32'h00000000, 32'h0,        6'd0,  1'b0, 32'h0, 32'h0, 1'b0},
        '{1'b0, REG_COEF_E,   32'h0,        32'h55555555, 6'd48, 1'b0, 32'h0, 32'h0, 1'b0}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    q24_t        source_value;
    logic [PROBE_W-1:0] probe_index;
    logic        out_valid;
    logic        out_stall;
    q24_t        probe_electric;
    q24_t        probe_magnetic;
    logic        saturated;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    // grid copy and register copy for prediction
    q24_t grid_e [NCELL];
    q24_t grid_h [NCELL-1];
    q24_t left_end, left_nb, right_end, right_nb;
    q24_t k_e, k_h, k_mur;
    logic mur_on;
    logic clip_seen;

    probe_rec_t pending_probe [$];
    probe_rec_t want;

    int err_count;
    int steps_sent;
    int results_seen;
    int clipped_seen;
    int mur_steps;
    int settings_used;
    int cycles;

    fdtd_1d_field_update #(.CELLS(NCELL)) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .source_value   (source_value),
        .probe_index    (probe_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .probe_electric (probe_electric),
        .probe_magnetic (probe_magnetic),
        .saturated      (saturated),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic wide_t widen(input q24_t x);
        return x;
    endfunction

    // exact product, round half up, floor shift back to Q8.24
    function automatic wide_t scale_q24(input wide_t diff, input q24_t k);
        wide_t kw;
        wide_t p;
        kw = k;
        p  = diff * kw + 66'sd8388608;
        return p >>> FRAC_W;
    endfunction

    function automatic q24_t clamp32(input wide_t v);
        wide_t hi;
        wide_t lo;
        hi = DATA_MAX;
        lo = DATA_MIN;
        if (v > hi)
        begin
            clip_seen = 1'b1;
            return DATA_MAX;
        end
        if (v < lo)
        begin
            clip_seen = 1'b1;
            return DATA_MIN;
        end
        return v[DATA_W-1:0];
    endfunction

    task automatic advance_grid(input q24_t src, input logic [5:0] probe,
                                output probe_rec_t r);
        q24_t nl;
        q24_t nr;
        clip_seen = 1'b0;
        left_end  = grid_e[0];
        right_end = grid_e[NCELL-1];
        for (int i = 0; i < NCELL - 1; i++)
            grid_h[i] = clamp32(widen(grid_h[i]) +
                                scale_q24(widen(grid_e[i+1]) - widen(grid_e[i]), k_h));
        for (int i = 1; i < NCELL - 1; i++)
            grid_e[i] = clamp32(widen(grid_e[i]) +
                                scale_q24(widen(grid_h[i]) - widen(grid_h[i-1]), k_e));
        grid_e[SRC_CELL] = clamp32(widen(grid_e[SRC_CELL]) + widen(src));
        if (mur_on == BND_REFLECT)
        begin
            grid_e[0]       = '0;
            grid_e[NCELL-1] = '0;
        end
        else
        begin
            nl = clamp32(widen(left_nb) +
                         scale_q24(widen(grid_e[1]) - widen(left_end), k_mur));
            nr = clamp32(widen(right_nb) +
                         scale_q24(widen(grid_e[NCELL-2]) - widen(right_end), k_mur));
            grid_e[0]       = nl;
            grid_e[NCELL-1] = nr;
        end
        left_nb  = grid_e[1];
        right_nb = grid_e[NCELL-2];
        r.e = '0;
        r.h = '0;
        if (probe < NCELL)
            r.e = grid_e[probe];
        if (probe < NCELL - 1)
            r.h = grid_h[probe];
        r.sat = clip_seen;
    endtask

    task automatic send_step(input q24_t src, input logic [5:0] probe,
                             input logic typed, input probe_rec_t typed_rec);
        probe_rec_t got;
        @(negedge clk);
        in_valid     <= 1'b1;
        source_value <= src;
        probe_index  <= probe;
        cfg_we       <= 1'b0;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        advance_grid(src, probe, got);
        pending_probe.push_back(typed ? typed_rec : got);
        steps_sent++;
        if (mur_on == BND_MUR)
            mur_steps++;
    endtask

    // sender holds off until every outstanding step has reported
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        cfg_we   <= 1'b0;
        while (pending_probe.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(input cfg_reg_t sel, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        case (sel)
            REG_COEF_E:   k_e    = val;
            REG_COEF_H:   k_h    = val;
            REG_MUR_COEF: k_mur  = val;
            REG_BND_MODE: mur_on = val[0];
            default: ;
        endcase
    endtask

    function automatic q24_t pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 32'h7FFFFFFF;
            1:       return 32'h80000000;
            2:       return 32'h00000000;
            3:       return 32'h01000000;
            default: return 32'hFFFFFFFF;
        endcase
    endfunction

    // mostly quiet steps and small pulses, now and then a full-range kick
    function automatic q24_t pick_source();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return '0;
            4, 5, 6:    return q24_t'($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000;
            7:          return q24_t'($urandom_range(0, 32'h03FFFFFF)) - 32'sh02000000;
            default:    return $urandom;
        endcase
    endfunction

    task automatic new_setting(input int kind);
        q24_t ke;
        q24_t kh;
        q24_t km;
        logic mode;
        mode = 1'($urandom_range(0, 1));
        case (kind)
            0:
            begin
                ke   = 32'h00800000;
                kh   = 32'h00800000;
                km   = -32'sh00555555;
                mode = BND_MUR;
            end
            1:
            begin
                ke = pick_extreme();
                kh = pick_extreme();
                km = pick_extreme();
            end
            2:
            begin
                ke = $urandom;
                kh = $urandom;
                km = $urandom;
            end
            default:
            begin
                ke = $urandom_range(0, 32'h01000000);
                kh = $urandom_range(0, 32'h01000000);
                km = q24_t'(0) - q24_t'($urandom_range(0, 32'h01000000));
            end
        endcase
        drain_results();
        write_cfg(REG_COEF_E, ke);
        write_cfg(REG_COEF_H, kh);
        write_cfg(REG_MUR_COEF, km);
        write_cfg(REG_BND_MODE, ($urandom & ~32'h1) | 32'(mode));
        settings_used++;
    endtask

    initial
    begin
        int          rand_items;
        int          phase;
        int          per_phase;
        int          burst_left;
        int          gap;
        stim_row_t   row;
        probe_rec_t  typed_rec;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        source_value = '0;
        probe_index  = '0;
        out_stall    = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_COEF_E;
        cfg_data     = '0;
        err_count    = 0;
        steps_sent   = 0;
        results_seen = 0;
        clipped_seen = 0;
        mur_steps    = 0;
        settings_used = 1;
        rand_items   = 0;
        phase        = 0;
        burst_left   = 0;

        for (int i = 0; i < NCELL; i++)
            grid_e[i] = '0;
        for (int i = 0; i < NCELL - 1; i++)
            grid_h[i] = '0;
        left_end  = '0;
        left_nb   = '0;
        right_end = '0;
        right_nb  = '0;
        k_e    = COEF_E_RST;
        k_h    = COEF_H_RST;
        k_mur  = MUR_COEF_RST;
        mur_on = BND_REFLECT;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        for (int n = 0; n < $size(DIRECTED); n++)
        begin
            row = DIRECTED[n];
            if (row.is_cfg)
            begin
                drain_results();
                write_cfg(row.cfg_sel, row.cfg_val);
                settings_used++;
            end
            else
            begin
                typed_rec.e   = row.exp_e;
                typed_rec.h   = row.exp_h;
                typed_rec.sat = row.exp_sat;
                send_step(row.src, row.probe, row.typed, typed_rec);
            end
        end

        while (rand_items < RAND_ITEMS)
        begin
            if (phase == 0)
                new_setting(0);
            else if (phase == 1)
                new_setting(1);
            else
                new_setting($urandom_range(0, 5));
            per_phase = $urandom_range(120, 180);
            if (per_phase > RAND_ITEMS - rand_items)
                per_phase = RAND_ITEMS - rand_items;
            repeat (per_phase)
            begin
                if ($urandom_range(0, 63) == 0)
                    drain_results();
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 160);
                    if (gap != 0)
                    begin
                        @(negedge clk);
                        in_valid <= 1'b0;
                        cfg_we   <= 1'b0;
                        repeat (gap - 1) @(negedge clk);
                    end
                end
                burst_left--;
                send_step(pick_source(), PROBE_W'($urandom_range(0, NCELL - 1)),
                          1'b0, '0);
                rand_items++;
            end
            phase++;
        end

        drain_results();
        repeat (LATENCY + 8) @(posedge clk);
        if (pending_probe.size() != 0)
        begin
            err_count++;
            $display("%0t %0d probe results never arrived", $time, pending_probe.size());
        end

        $display("ran %0d grid steps under %0d register settings, %0d with absorbing ends",
                 steps_sent, settings_used, mur_steps);
        $display("checked %0d probe transfers, %0d of them flagged as clipped",
                 results_seen, clipped_seen);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // receiver back-pressure: quiet stretches, solid stalls and dithered stalls
    initial
    begin
        int   seg;
        int   kind;
        logic lvl;
        @(negedge clk);
        forever
        begin
            kind = $urandom_range(0, 3);
            seg  = (kind == 1) ? $urandom_range(1, 160) : $urandom_range(1, 300);
            repeat (seg)
            begin
                case (kind)
                    1:       lvl = 1'b1;
                    2:       lvl = 1'($urandom_range(0, 1));
                    default: lvl = 1'b0;
                endcase
                out_stall <= lvl;
                @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (saturated)
                clipped_seen++;
            if (pending_probe.size() == 0)
            begin
                err_count++;
                $display("%0t unexpected transfer: expected none, got e %h h %h sat %b",
                         $time, probe_electric, probe_magnetic, saturated);
            end
            else
            begin
                want = pending_probe.pop_front();
                if (probe_electric !== want.e)
                begin
                    err_count++;
                    $display("%0t probe_electric: expected %h, got %h",
                             $time, want.e, probe_electric);
                end
                if (probe_magnetic !== want.h)
                begin
                    err_count++;
                    $display("%0t probe_magnetic: expected %h, got %h",
                             $time, want.h, probe_magnetic);
                end
                if (saturated !== want.sat)
                begin
                    err_count++;
                    $display("%0t saturated: expected %b, got %b",
                             $time, want.sat, saturated);
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_CAP)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t run stopped at the cycle limit", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
